FILE: sv/pconv_pkg.sv
// shared constants and codes for the partial convolution block
// no dependencies; imported by partial_convolution_q15 and its bench
`default_nettype none

package pconv_pkg;

  // sample store depth and derived widths
  localparam int MAX_LEN = 32;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int FILL_W  = $clog2(MAX_LEN + 1);

  // q15 datapath
  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int ACC_W    = PROD_W + $clog2(MAX_LEN) + 1;
  localparam int FRAC_W   = 15;
  localparam int SHIFT_W  = ACC_W - FRAC_W;

  // configuration register width and index
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEN_A       = 2'd0,
    CFG_LEN_B       = 2'd1,
    CFG_FIRST_INDEX = 2'd2,
    CFG_NUM_POINTS  = 2'd3
  } pconv_cfg_e;

  // input item kinds
  localparam int OP_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_START  = 2'd2
  } pconv_op_e;

endpackage

`default_nettype wire

FILE: sv/partial_convolution_q15.sv
// partial convolution of two q15 sequences held in two sample memories
// depends on pconv_pkg
`default_nettype none

// Samples of sequence A and B arrive on the input stream one per transfer
// (tuser 0 loads A, 1 loads B) and are written to two 32-entry synchronous
// memories; while idle, a load is taken every cycle. A start transfer (tuser
// 2) runs the convolution points first_index .. first_index+num_points-1,
// each an exact 38-bit multiply-accumulate, arithmetic shift right by 15 and
// saturation to 16 bits, and streams them out with tlast on the final point.
// A range or length error produces one result with value 0, tuser 1 and
// tlast set; a start that passes the check with num_points 0 produces
// nothing. Loads after a start refill both memories from entry 0. The block
// takes one multiply-accumulate term per cycle while issuing, through a
// single multiplier fed by one read port of each memory; a point has at most
// min(len_a, len_b) terms. No input is taken while a start runs. Memories are
// written only when idle and their read data is used only while a start runs,
// so used reads and writes never meet on one entry. Configuration writes are
// always taken and must be issued while the block is idle.
module partial_convolution_q15 (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write channel
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [pconv_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [pconv_pkg::CFG_W-1:0]       cfg_data_i,
  // input stream
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  input  wire logic [pconv_pkg::SAMPLE_W-1:0]    s_axis_tdata,  // [15:0] sample
  input  wire logic [pconv_pkg::OP_W-1:0]        s_axis_tuser,  // [1:0] operation
  // result stream
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output      logic [pconv_pkg::SAMPLE_W-1:0]    m_axis_tdata,  // [15:0] out_value
  output      logic                              m_axis_tuser,  // [0] status
  output      logic                              m_axis_tlast   // last_point
);
  import pconv_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_SETUP,
    ST_MAC,
    ST_DRAIN
  } state_e;

  state_e state_q;

  // configuration registers
  logic [CFG_W-1:0] len_a_q, len_b_q, first_index_q, num_points_q;

  // memory write pointers
  logic [FILL_W-1:0] fill_a_q, fill_b_q;

  // point sequencer
  logic [CFG_W-1:0] n_q;       // current convolution index
  logic [CFG_W-1:0] cnt_q;     // points still to produce
  logic [CFG_W-1:0] k_q;       // current A index
  logic [CFG_W-1:0] khi_q;     // last A index of the point
  logic             first_q;   // next issue is the first term

  // output register
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_value_q;
  logic                out_status_q;
  logic                out_last_q;

  // sample memories
  logic [SAMPLE_W-1:0] mem_a [MAX_LEN];
  logic [SAMPLE_W-1:0] mem_b [MAX_LEN];
  logic [SAMPLE_W-1:0] rd_a_q, rd_b_q;

  // mac pipeline
  logic              v1_q, f1_q, l1_q;
  logic              v2_q, f2_q, l2_q;
  logic [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]  acc_q;
  logic              acc_done_q;

  logic s_xfer, m_xfer, cfg_xfer, out_free;
  logic wr_a, wr_b, issue;
  logic [CFG_W-1:0] k_lo, k_hi, b_idx;
  logic [CFG_W:0]   n_plus1, len_sum_m1, range_end;
  logic             bad_start;
  logic [SHIFT_W-1:0]  acc_shr;
  logic [SAMPLE_W-1:0] sat_value;

  assign cfg_ready_o   = 1'b1;
  assign cfg_xfer      = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign m_xfer        = m_axis_tvalid && m_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  // loads beyond the memory depth are dropped
  assign wr_a = s_xfer && (s_axis_tuser == OP_LOAD_A) && (fill_a_q != FILL_W'(MAX_LEN));
  assign wr_b = s_xfer && (s_axis_tuser == OP_LOAD_B) && (fill_b_q != FILL_W'(MAX_LEN));

  // range check on start: lengths in 1..MAX_LEN and last point inside the output
  assign len_sum_m1 = {1'b0, len_a_q} + {1'b0, len_b_q} - (CFG_W+1)'(1);
  assign range_end  = {1'b0, first_index_q} + {1'b0, num_points_q};
  assign bad_start  = (len_a_q == '0) || (len_b_q == '0) ||
                      ({1'b0, len_a_q} > (CFG_W+1)'(MAX_LEN)) ||
                      ({1'b0, len_b_q} > (CFG_W+1)'(MAX_LEN)) ||
                      (range_end > len_sum_m1);

  // term bounds of point n: max(0, n+1-len_b) .. min(n, len_a-1)
  assign n_plus1 = {1'b0, n_q} + (CFG_W+1)'(1);
  always_comb begin
    if (n_plus1 > {1'b0, len_b_q}) begin
      k_lo = CFG_W'(n_plus1 - {1'b0, len_b_q});
    end else begin
      k_lo = '0;
    end
    if (n_q < len_a_q - CFG_W'(1)) begin
      k_hi = n_q;
    end else begin
      k_hi = len_a_q - CFG_W'(1);
    end
  end

  assign issue = (state_q == ST_MAC);
  assign b_idx = n_q - k_q;

  // floor shift by 15 then saturate
  assign acc_shr = acc_q[ACC_W-1:FRAC_W];
  always_comb begin
    if (!acc_shr[SHIFT_W-1] && (acc_shr[SHIFT_W-2:SAMPLE_W-1] != '0)) begin
      sat_value = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (acc_shr[SHIFT_W-1] && (acc_shr[SHIFT_W-2:SAMPLE_W-1] != '1)) begin
      sat_value = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat_value = acc_shr[SAMPLE_W-1:0];
    end
  end

  // sample memories, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[fill_a_q[ADDR_W-1:0]] <= s_axis_tdata;
    end
    rd_a_q <= mem_a[k_q[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b[fill_b_q[ADDR_W-1:0]] <= s_axis_tdata;
    end
    rd_b_q <= mem_b[b_idx[ADDR_W-1:0]];
  end

  // mac datapath, no reset on payload
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'($signed(rd_a_q) * $signed(rd_b_q));
    if (v2_q) begin
      if (f2_q) begin
        acc_q <= ACC_W'($signed(prod_q));
      end else begin
        acc_q <= acc_q + ACC_W'($signed(prod_q));
      end
    end
  end

  // mac pipeline tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      f1_q       <= 1'b0;
      l1_q       <= 1'b0;
      v2_q       <= 1'b0;
      f2_q       <= 1'b0;
      l2_q       <= 1'b0;
      acc_done_q <= 1'b0;
    end else begin
      v1_q <= issue;
      f1_q <= first_q;
      l1_q <= (k_q == khi_q);
      v2_q <= v1_q;
      f2_q <= f1_q;
      l2_q <= l1_q;
      if (state_q == ST_SETUP) begin
        acc_done_q <= 1'b0;
      end else if (v2_q && l2_q) begin
        acc_done_q <= 1'b1;
      end
    end
  end

  // control, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      len_a_q       <= CFG_W'(1);
      len_b_q       <= CFG_W'(1);
      first_index_q <= '0;
      num_points_q  <= '0;
      fill_a_q      <= '0;
      fill_b_q      <= '0;
      n_q           <= '0;
      cnt_q         <= '0;
      k_q           <= '0;
      khi_q         <= '0;
      first_q       <= 1'b0;
      out_valid_q   <= 1'b0;
      out_value_q   <= '0;
      out_status_q  <= 1'b0;
      out_last_q    <= 1'b0;
    end else begin
      if (cfg_xfer) begin
        case (cfg_index_i)
          CFG_LEN_A:       len_a_q       <= cfg_data_i;
          CFG_LEN_B:       len_b_q       <= cfg_data_i;
          CFG_FIRST_INDEX: first_index_q <= cfg_data_i;
          CFG_NUM_POINTS:  num_points_q  <= cfg_data_i;
          default: ;
        endcase
      end

      if (m_xfer) begin
        out_valid_q <= 1'b0;
      end

      if (wr_a) begin
        fill_a_q <= fill_a_q + FILL_W'(1);
      end
      if (wr_b) begin
        fill_b_q <= fill_b_q + FILL_W'(1);
      end

      case (state_q)
        ST_IDLE: begin
          if (s_xfer && (s_axis_tuser == OP_START)) begin
            fill_a_q <= '0;
            fill_b_q <= '0;
            n_q      <= first_index_q;
            cnt_q    <= num_points_q;
            if (bad_start) begin
              state_q <= ST_ERR;
            end else if (num_points_q != '0) begin
              state_q <= ST_SETUP;
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_value_q  <= '0;
            out_status_q <= 1'b1;
            out_last_q   <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        ST_SETUP: begin
          k_q     <= k_lo;
          khi_q   <= k_hi;
          first_q <= 1'b1;
          state_q <= ST_MAC;
        end
        ST_MAC: begin
          first_q <= 1'b0;
          if (k_q == khi_q) begin
            state_q <= ST_DRAIN;
          end else begin
            k_q <= k_q + CFG_W'(1);
          end
        end
        ST_DRAIN: begin
          if (acc_done_q && out_free) begin
            out_valid_q  <= 1'b1;
            out_value_q  <= sat_value;
            out_status_q <= 1'b0;
            out_last_q   <= (cnt_q == CFG_W'(1));
            n_q          <= n_q + CFG_W'(1);
            cnt_q        <= cnt_q - CFG_W'(1);
            if (cnt_q == CFG_W'(1)) begin
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_SETUP;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // an error result is always the last of its run
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("error result without tlast");

  // memory reads are only in flight right after an issue cycle
  a_v1_from_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> $past(state_q == ST_MAC))
    else $error("read tag without issue");

  // a point is emitted only once the pipeline is empty
  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && acc_done_q) |-> (!v1_q && !v2_q))
    else $error("point finished with terms in flight");

  // term index never passes the upper bound while issuing
  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (k_q <= khi_q))
    else $error("term index beyond bound");

  // write pointers never pass the memory depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_a_q <= FILL_W'(MAX_LEN)) && (fill_b_q <= FILL_W'(MAX_LEN)))
    else $error("fill pointer beyond depth");

endmodule

`default_nettype wire

FILE: bench/tb_partial_convolution_q15.sv
// self-checking bench for partial_convolution_q15: loads q15 sample stores,
// runs partial convolutions and checks each output point against its own predictor
// depends on pconv_pkg and partial_convolution_q15
module tb_partial_convolution_q15;
  timeunit 1ns;
  timeprecision 1ps;

  import pconv_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 10;
  localparam int TOTAL_ITEMS    = 460;
  // settle time after the last point; a point has at most MAX_LEN terms
  localparam int SETTLE_CYCLES  = 60;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLDOFF_AFTER  = 100;
  localparam int HOLDOFF_CYCLES = 600;
  localparam int MAX_REPORTS    = 10;
  localparam int REG_MAX        = (1 << CFG_W) - 1;

  localparam logic [OP_W-1:0]            OP_UNUSED        = 2'd3;
  localparam logic                       STATUS_OK        = 1'b0;
  localparam logic                       STATUS_RANGE_ERR = 1'b1;
  localparam logic signed [SAMPLE_W-1:0] Q15_MAX          = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] Q15_MIN          = 16'sh8000;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SAMPLE_W-1:0] sample;
  } conv_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       status;
    logic                       last;
  } conv_point_t;

  typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_SPARSE} rx_pattern_e;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [SAMPLE_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]      s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0]  m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  partial_convolution_q15 DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // items waiting for the driver, and points the block still owes us
  conv_item_t  pending_items[$];
  conv_point_t expected_points[$];

  // shadow copy of the block state, updated on every accepted transfer
  logic signed [SAMPLE_W-1:0] shadow_a [MAX_LEN];
  logic signed [SAMPLE_W-1:0] shadow_b [MAX_LEN];
  int shadow_fill_a = 0;
  int shadow_fill_b = 0;
  int reg_len_a     = 1;
  int reg_len_b     = 1;
  int reg_first     = 0;
  int reg_count     = 0;

  // generator side bookkeeping
  int items_queued   = 0;
  int items_accepted = 0;

  int mismatches   = 0;
  int results_seen = 0;
  int idle_cycles  = 0;

  // driver and sink pacing
  int          burst_left   = 0;
  int          gap_left     = 0;
  int          rx_left      = 0;
  int          rx_tick      = 0;
  int          holdoff_left = 0;
  bit          holdoff_done = 1'b0;
  rx_pattern_e rx_pattern   = RX_STEADY;

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // one point of the full convolution: exact sum, floor shift, saturation
  function automatic logic signed [SAMPLE_W-1:0] conv_point_q15(input int n);
    longint acc;
    int     k_lo;
    int     k_hi;
    int     k;
    acc  = 0;
    k_lo = (n + 1 > reg_len_b) ? n + 1 - reg_len_b : 0;
    k_hi = (n < reg_len_a - 1) ? n : reg_len_a - 1;
    for (k = k_lo; k <= k_hi; k++)
      acc += longint'(shadow_a[k]) * longint'(shadow_b[n - k]);
    acc = acc >>> FRAC_W;
    if (acc > longint'(Q15_MAX)) return Q15_MAX;
    if (acc < longint'(Q15_MIN)) return Q15_MIN;
    return SAMPLE_W'(acc);
  endfunction

  // extremes and values near zero show up often
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return Q15_MAX;
      1:       return Q15_MIN;
      2:       return SAMPLE_W'($urandom_range(0, 6)) - SAMPLE_W'(3);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic queue_item(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] sample);
    conv_item_t entry;
    entry.op     = op;
    entry.sample = sample;
    pending_items.push_back(entry);
    items_queued++;
  endtask

  // all items taken, all points back, then time for a start with no output
  task automatic wait_idle();
    do @(posedge clk_i);
    while (items_accepted != items_queued || expected_points.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // called in step with the rising clock while the block is idle
  task automatic program_regs(input int la, input int lb, input int fi, input int np);
    pconv_cfg_e reg_idx [4];
    int         reg_val [4];
    int         r;
    reg_idx = '{CFG_LEN_A, CFG_LEN_B, CFG_FIRST_INDEX, CFG_NUM_POINTS};
    reg_val = '{la, lb, fi, np};
    for (r = 0; r < 4; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= reg_idx[r];
      cfg_data_i  <= CFG_W'(reg_val[r]);
      do @(posedge clk_i);
      while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_start();
    queue_item(OP_START, rand_sample());
    wait_idle();
  endtask

  initial begin : stimulus
    int               i;
    int               la;
    int               lb;
    int               fi;
    int               np;
    int               total;
    int               pick;
    int               n_seq;
    int               seq;
    int               kind;
    int               na;
    int               nb;
    int               cap_a;
    int               cap_b;
    logic [OP_W-1:0]  op;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: a start that asks for no points
    run_start();

    // fill both stores completely so that every later start reads written
    // entries; one more load per side hits a full store
    program_regs(MAX_LEN, MAX_LEN, 0, REG_MAX);
    for (i = 0; i <= MAX_LEN; i++)
      queue_item(OP_LOAD_A, Q15_MIN);
    for (i = 0; i <= MAX_LEN; i++)
      queue_item(OP_LOAD_B, (i < MAX_LEN / 2) ? Q15_MAX : Q15_MIN);
    queue_item(OP_UNUSED, 16'hffff);
    // full convolution: saturates low at the head and high at the tail
    run_start();

    // zero length, lengths beyond the store, every field at its top value
    program_regs(0, 5, 0, 1);
    run_start();
    program_regs(MAX_LEN + 1, REG_MAX, 0, 1);
    run_start();
    program_regs(REG_MAX, REG_MAX, REG_MAX, REG_MAX);
    run_start();
    // range one point too long, then exactly at the end with no points
    program_regs(5, 3, 6, 2);
    run_start();
    program_regs(5, 3, 7, 0);
    run_start();
    // single point, min times min saturates to max
    program_regs(1, 1, 0, 1);
    queue_item(OP_LOAD_A, Q15_MIN);
    queue_item(OP_LOAD_B, Q15_MIN);
    run_start();
    // short full convolution with mixed signs
    program_regs(2, 2, 0, 3);
    queue_item(OP_LOAD_A, Q15_MAX);
    queue_item(OP_LOAD_A, Q15_MIN);
    queue_item(OP_LOAD_B, Q15_MAX);
    queue_item(OP_LOAD_B, 16'h0001);
    run_start();

    // random part: one register setting per phase, a few sequences each
    while (items_queued < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        la = $urandom_range(1, 8);
        lb = $urandom_range(1, 8);
      end else if (pick < 17) begin
        la = $urandom_range(1, MAX_LEN);
        lb = $urandom_range(1, MAX_LEN);
      end else if (pick < 18) begin
        la = MAX_LEN;
        lb = MAX_LEN;
      end else begin
        la = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_LEN + 1, REG_MAX);
        lb = $urandom_range(0, REG_MAX);
      end

      total = la + lb - 1;
      if (la == 0 || lb == 0 || la > MAX_LEN || lb > MAX_LEN) begin
        fi = $urandom_range(0, REG_MAX);
        np = $urandom_range(0, REG_MAX);
      end else if ($urandom_range(0, 7) == 0) begin
        // ask for more points than the output holds
        fi = $urandom_range(0, REG_MAX);
        np = $urandom_range(0, REG_MAX);
        if (fi + np <= total) begin
          np = REG_MAX;
          if (fi == 0) fi = 1;
        end
      end else begin
        fi = $urandom_range(0, total - 1);
        np = $urandom_range(0, total - fi);
      end
      program_regs(la, lb, fi, np);

      cap_a = (la > MAX_LEN) ? MAX_LEN : la;
      cap_b = (lb > MAX_LEN) ? MAX_LEN : lb;
      n_seq = $urandom_range(2, 5);
      for (seq = 0; seq < n_seq && items_queued < TOTAL_ITEMS; seq++) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          // noise: any code, unused one included
          repeat ($urandom_range(1, 6))
            queue_item(OP_W'($urandom_range(0, 3)), rand_sample());
        end else if (kind == 1) begin
          // run one store past full, then start
          op = ($urandom_range(0, 1) == 0) ? OP_LOAD_A : OP_LOAD_B;
          repeat ($urandom_range(MAX_LEN + 1, MAX_LEN + 4))
            queue_item(op, rand_sample());
          queue_item(OP_START, rand_sample());
        end else begin
          // usual use: refill both sequences, loads interleaved, then start
          na = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cap_a) : cap_a;
          nb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cap_b) : cap_b;
          while (na > 0 || nb > 0) begin
            if (nb == 0 || (na > 0 && $urandom_range(0, 1) == 0)) begin
              queue_item(OP_LOAD_A, rand_sample());
              na--;
            end else begin
              queue_item(OP_LOAD_B, rand_sample());
              nb--;
            end
          end
          queue_item(OP_START, rand_sample());
        end
      end
      // sender pauses here until every owed point is back
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("PASS partial_convolution_q15");
    end else begin
      $display("FAIL partial_convolution_q15");
    end
    $finish;
  end

  // input driver: bursts of random length, random gaps between them
  always @(posedge clk_i or negedge rst_ni) begin : item_driver
    conv_item_t entry;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        entry = pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= entry.sample;
        s_axis_tuser  <= entry.op;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink: steady, random or sparse ready, plus one long hold-off
  // while the sender still has items so the block backs up to its input
  always @(posedge clk_i or negedge rst_ni) begin : result_sink
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_left      = 0;
      rx_tick      = 0;
      holdoff_left = 0;
    end else begin
      rx_tick++;
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_axis_tready <= 1'b0;
      end else if (!holdoff_done && results_seen >= HOLDOFF_AFTER &&
                   items_queued > items_accepted + 2) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_pattern = rx_pattern_e'($urandom_range(0, 2));
          rx_left    = $urandom_range(16, 200);
        end else begin
          rx_left--;
        end
        case (rx_pattern)
          RX_STEADY: m_axis_tready <= 1'b1;
          RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default:   m_axis_tready <= (rx_tick % 4 == 0);
        endcase
      end
    end
  end

  // shadow state update, point prediction, result check and watchdog
  always @(posedge clk_i) begin : scoreboard
    conv_point_t want;
    int          p;
    if (!rst_ni) begin
      shadow_fill_a = 0;
      shadow_fill_b = 0;
      reg_len_a     = 1;
      reg_len_b     = 1;
      reg_first     = 0;
      reg_count     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_LEN_A:       reg_len_a = cfg_data_i;
          CFG_LEN_B:       reg_len_b = cfg_data_i;
          CFG_FIRST_INDEX: reg_first = cfg_data_i;
          CFG_NUM_POINTS:  reg_count = cfg_data_i;
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        items_accepted++;
        case (s_axis_tuser)
          OP_LOAD_A: begin
            if (shadow_fill_a < MAX_LEN) begin
              shadow_a[shadow_fill_a] = s_axis_tdata;
              shadow_fill_a++;
            end
          end
          OP_LOAD_B: begin
            if (shadow_fill_b < MAX_LEN) begin
              shadow_b[shadow_fill_b] = s_axis_tdata;
              shadow_fill_b++;
            end
          end
          OP_START: begin
            // next loads refill from entry 0, old contents stay
            shadow_fill_a = 0;
            shadow_fill_b = 0;
            if (reg_len_a == 0 || reg_len_b == 0 || reg_len_a > MAX_LEN ||
                reg_len_b > MAX_LEN || reg_first + reg_count > reg_len_a + reg_len_b - 1) begin
              want.value  = '0;
              want.status = STATUS_RANGE_ERR;
              want.last   = 1'b1;
              expected_points.push_back(want);
            end else begin
              for (p = 0; p < reg_count; p++) begin
                want.value  = conv_point_q15(reg_first + p);
                want.status = STATUS_OK;
                want.last   = (p == reg_count - 1);
                expected_points.push_back(want);
              end
            end
          end
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d not expected: value %0d status %0b last %0b",
                     results_seen, $signed(m_axis_tdata), m_axis_tuser, m_axis_tlast);
        end else begin
          want = expected_points.pop_front();
          if (m_axis_tdata !== want.value || m_axis_tuser !== want.status ||
              m_axis_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result %0d mismatch: want %0d/%0b/%0b got %0d/%0b/%0b",
                       results_seen, $signed(want.value), want.status, want.last,
                       $signed(m_axis_tdata), m_axis_tuser, m_axis_tlast);
          end
        end
      end

      // any transfer on any channel counts as progress
      if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL partial_convolution_q15");
        $finish;
      end
    end
  end

endmodule
